@@ rtl/gpoq_pkg.sv @@
// Shared types and constants for the grid page overlap query unit.
`timescale 1ns / 1ps
`default_nettype none
package gpoq_pkg;

    localparam int DIV_W = 32;
    localparam int CNT_W = 7;
    localparam int IDX_W = 6;
    localparam int POS_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int DEF_MAX_COLUMNS = 8;
    localparam int DEF_MAX_ROWS = 8;

    localparam logic [1:0] ST_PAGE      = 2'd0;
    localparam logic [1:0] ST_MISS      = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_W = 3'd4;

    typedef enum logic [2:0] {
        DOP_COLS, DOP_ROWS, DOP_PW, DOP_PH, DOP_FC, DOP_LC, DOP_FR, DOP_LR
    } t_div_op;

    typedef struct packed {
        logic       load_query;
        logic       div_start;
        t_div_op    div_op;
        logic       init_scan;
        logic       emit;
        logic [1:0] emit_status;
    } t_dp_cmd;

    typedef struct packed {
        logic cfg_invalid;
        logic too_large;
        logic miss;
        logic div_busy;
        logic div_done;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ rtl/gpoq_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gpoq_div
    import gpoq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quot,
    output logic [DIV_W-1:0]      o_rem
);

    localparam int STEP_W = $clog2(DIV_W);

    logic [DIV_W-1:0]  r_rem, r_quot, r_div;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [DIV_W:0]    rem_sh, diff;

    assign rem_sh = {r_rem, r_quot[DIV_W-1]};
    assign diff   = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (!diff[DIV_W]) begin
                r_rem  <= diff[DIV_W-1:0];
                r_quot <= {r_quot[DIV_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[DIV_W-1:0];
                r_quot <= {r_quot[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

@@ rtl/gpoq_dp.sv @@
// Datapath: configuration, query registers, grid arithmetic, page scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module gpoq_dp
    import gpoq_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic [31:0]          i_query_min_x,
    input  wire logic [31:0]          i_query_min_y,
    input  wire logic [31:0]          i_query_max_x,
    input  wire logic [31:0]          i_query_max_y,
    input  wire logic                 i_stall,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    output logic                      o_valid,
    output logic [IDX_W-1:0]          o_page_index,
    output logic [POS_W-1:0]          o_page_column,
    output logic [POS_W-1:0]          o_page_row,
    output logic [1:0]                o_status,
    output logic                      o_last
);

    logic signed [31:0] r_bmin_x, r_bmin_y, r_bmax_x, r_bmax_y;
    logic [30:0]        r_mpw;
    logic signed [31:0] r_qx0, r_qy0, r_qx1, r_qy1;
    logic [DIV_W-1:0]   r_cols, r_rows, r_pw, r_ph;
    logic [CNT_W-1:0]   r_fc, r_lc, r_fr, r_lr, r_c, r_r;
    logic [IDX_W-1:0]   r_idx;

    logic               r_o_valid, r_o_last;
    logic [IDX_W-1:0]   r_o_idx;
    logic [POS_W-1:0]   r_o_col, r_o_row;
    logic [1:0]         r_o_status;

    logic signed [31:0] cx0, cy0, cx1, cy1;
    logic [32:0]        w_full, h_full, ox0, ox1, oy0, oy1;
    logic [DIV_W-1:0]   dividend, divisor, quot, rem, q_ceil, q_lim;
    logic               div_busy, div_done, col_end, row_end, out_free;
    logic [CNT_W-1:0]   cols_n, span;
    logic [2*CNT_W-1:0] start_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bmin_x <= 32'sd0;
            r_bmin_y <= 32'sd0;
            r_bmax_x <= 32'sd65536;
            r_bmax_y <= 32'sd65536;
            r_mpw    <= 31'd16384;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_X: r_bmin_x <= i_cfg_data;
                CFG_MIN_Y: r_bmin_y <= i_cfg_data;
                CFG_MAX_X: r_bmax_x <= i_cfg_data;
                CFG_MAX_Y: r_bmax_y <= i_cfg_data;
                CFG_MAX_W: r_mpw    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_qx0 <= i_query_min_x;
            r_qy0 <= i_query_min_y;
            r_qx1 <= i_query_max_x;
            r_qy1 <= i_query_max_y;
        end
    end

    // Clipped query and the offsets of its edges from the board origin.
    assign cx0 = (r_qx0 > r_bmin_x) ? r_qx0 : r_bmin_x;
    assign cy0 = (r_qy0 > r_bmin_y) ? r_qy0 : r_bmin_y;
    assign cx1 = (r_qx1 < r_bmax_x) ? r_qx1 : r_bmax_x;
    assign cy1 = (r_qy1 < r_bmax_y) ? r_qy1 : r_bmax_y;

    assign w_full = {r_bmax_x[31], r_bmax_x} - {r_bmin_x[31], r_bmin_x};
    assign h_full = {r_bmax_y[31], r_bmax_y} - {r_bmin_y[31], r_bmin_y};
    assign ox0    = {cx0[31], cx0} - {r_bmin_x[31], r_bmin_x};
    assign ox1    = {cx1[31], cx1} - {r_bmin_x[31], r_bmin_x} - 33'd1;
    assign oy0    = {cy0[31], cy0} - {r_bmin_y[31], r_bmin_y};
    assign oy1    = {cy1[31], cy1} - {r_bmin_y[31], r_bmin_y} - 33'd1;

    always_comb begin
        case (i_cmd.div_op)
            DOP_COLS: begin dividend = w_full[31:0]; divisor = {1'b0, r_mpw}; end
            DOP_ROWS: begin dividend = h_full[31:0]; divisor = {1'b0, r_mpw}; end
            DOP_PW:   begin dividend = w_full[31:0]; divisor = r_cols;        end
            DOP_PH:   begin dividend = h_full[31:0]; divisor = r_rows;        end
            DOP_FC:   begin dividend = ox0[31:0];    divisor = r_pw;          end
            DOP_LC:   begin dividend = ox1[31:0];    divisor = r_pw;          end
            DOP_FR:   begin dividend = oy0[31:0];    divisor = r_ph;          end
            DOP_LR:   begin dividend = oy1[31:0];    divisor = r_ph;          end
            default:  begin dividend = '0;           divisor = '1;            end
        endcase
    end

    gpoq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    assign q_ceil = quot + DIV_W'(rem != '0);
    assign q_lim  = (i_cmd.div_op == DOP_LC) ? r_cols - 1'b1 : r_rows - 1'b1;

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            case (i_cmd.div_op)
                DOP_COLS: r_cols <= q_ceil;
                DOP_ROWS: r_rows <= q_ceil;
                DOP_PW:   r_pw   <= q_ceil;
                DOP_PH:   r_ph   <= q_ceil;
                DOP_FC:   r_fc   <= quot[CNT_W-1:0];
                DOP_FR:   r_fr   <= quot[CNT_W-1:0];
                DOP_LC, DOP_LR: begin
                    if (i_cmd.div_op == DOP_LC)
                        r_lc <= (quot > q_lim) ? q_lim[CNT_W-1:0] : quot[CNT_W-1:0];
                    else
                        r_lr <= (quot > q_lim) ? q_lim[CNT_W-1:0] : quot[CNT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Page scan in row-major order; the index is kept modulo the result width.
    assign cols_n     = r_cols[CNT_W-1:0];
    assign span       = r_lc - r_fc;
    assign start_prod = r_fr * cols_n;
    assign col_end    = (r_c == r_lc);
    assign row_end    = (r_r == r_lr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_scan) begin
            r_c   <= r_fc;
            r_r   <= r_fr;
            r_idx <= start_prod[IDX_W-1:0] + r_fc[IDX_W-1:0];
        end else if (i_cmd.emit && i_cmd.emit_status == ST_PAGE) begin
            if (col_end) begin
                r_c   <= r_fc;
                r_r   <= r_r + 1'b1;
                r_idx <= r_idx + cols_n[IDX_W-1:0] - span[IDX_W-1:0];
            end else begin
                r_c   <= r_c + 1'b1;
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status <= i_cmd.emit_status;
            if (i_cmd.emit_status == ST_PAGE) begin
                r_o_idx  <= r_idx;
                r_o_col  <= r_c[POS_W-1:0];
                r_o_row  <= r_r[POS_W-1:0];
                r_o_last <= col_end && row_end;
            end else begin
                r_o_idx  <= '0;
                r_o_col  <= '0;
                r_o_row  <= '0;
                r_o_last <= 1'b1;
            end
        end
    end

    assign o_stat.cfg_invalid = (r_bmax_x <= r_bmin_x) || (r_bmax_y <= r_bmin_y) ||
                                (r_mpw == '0);
    assign o_stat.too_large   = (r_cols > DIV_W'(MAX_COLUMNS)) ||
                                (r_rows > DIV_W'(MAX_ROWS));
    assign o_stat.miss        = (cx1 <= cx0) || (cy1 <= cy0);
    assign o_stat.div_busy    = div_busy;
    assign o_stat.div_done    = div_done;
    assign o_stat.scan_last   = col_end && row_end;
    assign o_stat.out_free    = out_free;

    assign o_valid       = r_o_valid;
    assign o_page_index  = r_o_idx;
    assign o_page_column = r_o_col;
    assign o_page_row    = r_o_row;
    assign o_status      = r_o_status;
    assign o_last        = r_o_last;

endmodule
`default_nettype wire

@@ rtl/gpoq_ctrl.sv @@
// Controller: sequences the checks, the divisions and the page scan of one request.
`timescale 1ns / 1ps
`default_nettype none
module gpoq_ctrl
    import gpoq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DSTART, S_DWAIT, S_GRID, S_CLIP, S_INIT, S_EMIT, S_STATUS
    } t_state;

    t_state     r_state, n_state;
    t_div_op    r_op, n_op;
    logic [1:0] r_code, n_code;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.div_op      = r_op;
        o_cmd.emit_status = ST_PAGE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_query = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.cfg_invalid) begin
                    n_code  = ST_INVALID;
                    n_state = S_STATUS;
                end else begin
                    n_op    = DOP_COLS;
                    n_state = S_DSTART;
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_DSTART;
                    case (r_op)
                        DOP_COLS: n_op = DOP_ROWS;
                        DOP_ROWS: n_state = S_GRID;
                        DOP_PW:   n_op = DOP_PH;
                        DOP_PH:   n_state = S_CLIP;
                        DOP_FC:   n_op = DOP_LC;
                        DOP_LC:   n_op = DOP_FR;
                        DOP_FR:   n_op = DOP_LR;
                        DOP_LR:   n_state = S_INIT;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_GRID: begin
                if (i_stat.too_large) begin
                    n_code  = ST_TOO_LARGE;
                    n_state = S_STATUS;
                end else begin
                    n_op    = DOP_PW;
                    n_state = S_DSTART;
                end
            end
            S_CLIP: begin
                if (i_stat.miss) begin
                    n_code  = ST_MISS;
                    n_state = S_STATUS;
                end else begin
                    n_op    = DOP_FC;
                    n_state = S_DSTART;
                end
            end
            S_INIT: begin
                o_cmd.init_scan = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.scan_last)
                        n_state = S_IDLE;
                end
            end
            S_STATUS: begin
                o_cmd.emit_status = r_code;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= DOP_COLS;
            r_code  <= ST_PAGE;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_code  <= n_code;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/grid_page_overlap_query_unit.sv @@
// Top level of the grid page overlap query unit.
//
// Channel  Direction  Handshake           Payload
// query    in         i_valid / o_stall   i_query_min_x/y, i_query_max_x/y
// result   out        o_valid / i_stall   o_page_index, o_page_column, o_page_row,
//                                         o_status, o_last
// config   in         i_cfg_we            i_cfg_index, i_cfg_data
//
// One request at a time. A full request runs eight divisions on one shared
// divider of 32 steps, then gives one page a cycle while the result channel
// is not stalled. Errors and misses end earlier with a single status result.
// Reset is synchronous and active low; configuration returns to its reset values.
// A stalled result holds in the output register; the scan waits for it.
`timescale 1ns / 1ps
`default_nettype none
module grid_page_overlap_query_unit
    import gpoq_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic signed [31:0]   i_query_min_x,
    input  wire logic signed [31:0]   i_query_min_y,
    input  wire logic signed [31:0]   i_query_max_x,
    input  wire logic signed [31:0]   i_query_max_y,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [IDX_W-1:0]          o_page_index,
    output logic [POS_W-1:0]          o_page_column,
    output logic [POS_W-1:0]          o_page_row,
    output logic [1:0]                o_status,
    output logic                      o_last
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    gpoq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    gpoq_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_query_min_x (i_query_min_x),
        .i_query_min_y (i_query_min_y),
        .i_query_max_x (i_query_max_x),
        .i_query_max_y (i_query_max_y),
        .i_stall       (i_stall),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_page_index  (o_page_index),
        .o_page_column (o_page_column),
        .o_page_row    (o_page_row),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    // A result is only written when the output register can take it.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result written over a held result");

    // An accepted request keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted without going busy");

    // Status results carry zero coordinates and close the request.
    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_PAGE) |-> o_last && (o_page_index == '0) &&
        (o_page_column == '0) && (o_page_row == '0))
        else $error("status result with page fields set");

    // The divider is never restarted in the middle of a division.
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider restarted while busy");

endmodule
`default_nettype wire
